FILE: hdl/csxt_pkg.sv
// Shared types and constants for the call stack exclusive time tracker.
`timescale 1ns / 1ps
package csxt_pkg;

  localparam int NUM_FUNCS   = 64;
  localparam int STACK_DEPTH = 64;

  localparam int ID_W        = 6;
  localparam int TS_W        = 32;
  localparam int TOTAL_W     = 48;
  localparam int LEVEL_W     = 7;
  localparam int STACK_AW    = $clog2(STACK_DEPTH);
  localparam int TOTAL_DEPTH = 2 ** ID_W;

  typedef enum logic [1:0] {
    CMD_START    = 2'd0,
    CMD_END      = 2'd1,
    CMD_READ     = 2'd2,
    CMD_READ_ALT = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_ORDER = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]      cmd;
    logic [ID_W-1:0] func_id;
    logic [TS_W-1:0] timestamp;
  } item_t;

  typedef struct packed {
    logic [ID_W-1:0]    out_id;
    logic [TS_W-1:0]    invocation_time;
    logic [TOTAL_W-1:0] total_time;
    logic [LEVEL_W-1:0] stack_level;
    logic [1:0]         status;
  } result_t;

  // controller to datapath step strobes
  typedef struct packed {
    logic load;
    logic eval;
    logic check;
    logic commit;
  } dp_cmd_t;

endpackage

FILE: hdl/call_stack_exclusive_time_core.sv
// Top level of the call stack exclusive time tracker.
//
// Input channel: an event transaction (cmd, func_id, timestamp in item_i) is
// taken at a rising edge where start is high and busy is low. cmd 0 opens an
// invocation, cmd 1 closes the top one, cmd 2 or 3 reads a function's total.
// Result channel: exactly one result per event, shown on result_o for one
// cycle with done_o high; the receiver cannot hold it off.
// Timing: busy is high while an event steps through eval, check and commit;
// the result strobe is registered from commit and comes when busy is
// already low again. A new event is taken only while busy is low, so the
// controller takes no new event before it is through with the last one;
// the stack and total memories have registered reads.
// Reset: the stack is emptied and every total reads as zero at once (valid
// bits per table entry); no clearing pass is needed. Stack memory contents
// are undefined until pushed.
`timescale 1ns / 1ps
module call_stack_exclusive_time_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  csxt_pkg::item_t   item_i,
  output logic              busy,
  output logic              done_o,
  output csxt_pkg::result_t result_o
);
  import csxt_pkg::*;

  dp_cmd_t dp_cmd;

  csxt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (dp_cmd)
  );

  csxt_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (dp_cmd),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

FILE: hdl/csxt_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module csxt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/csxt_ctrl.sv
// Controller: sequences one transaction through eval, check and commit.
`timescale 1ns / 1ps
module csxt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output csxt_pkg::dp_cmd_t cmd_o
);
  import csxt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_CHECK,
    S_COMMIT
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start) state_q <= S_EVAL;
        end
        S_EVAL:   state_q <= S_CHECK;
        S_CHECK:  state_q <= S_COMMIT;
        S_COMMIT: state_q <= S_IDLE;
        default:  state_q <= S_IDLE;
      endcase
    end
  end

  assign busy         = (state_q != S_IDLE);
  assign cmd_o.load   = start && (state_q == S_IDLE);
  assign cmd_o.eval   = (state_q == S_EVAL);
  assign cmd_o.check  = (state_q == S_CHECK);
  assign cmd_o.commit = (state_q == S_COMMIT);

endmodule

FILE: hdl/csxt_dp.sv
// Datapath: stack memories, total table, stack pointer and result register.
`timescale 1ns / 1ps
module csxt_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  csxt_pkg::dp_cmd_t cmd_i,
  input  csxt_pkg::item_t   item_i,
  output logic              done_o,
  output csxt_pkg::result_t result_o
);
  import csxt_pkg::*;

  // captured transaction
  logic [1:0]         cmd_q;
  logic [ID_W-1:0]    id_q;
  logic [TS_W-1:0]    ts_q;

  logic [LEVEL_W-1:0] sp_q, sp_d;
  logic [LEVEL_W-1:0] sp_m1;
  logic [TOTAL_DEPTH-1:0] valid_q;

  logic [TS_W-1:0]    incl_q, incl_d;
  logic [TS_W-1:0]    child_q;
  logic [TS_W-1:0]    inv_q;
  logic [TOTAL_W-1:0] total_old_q;
  status_e            status_q, status_d;

  logic               done_q;
  result_t            result_q;

  logic [TS_W-1:0]    start_rd, child_rd;
  logic [TOTAL_W-1:0] total_rd;
  logic               start_we, child_we, total_we;
  logic [STACK_AW-1:0] child_waddr;
  logic [TS_W-1:0]    child_wdata;
  logic [TOTAL_W-1:0] total_wdata;
  logic [ID_W-1:0]    total_raddr;

  logic               is_start, is_end, id_ok, end_ok;
  logic [TS_W:0]      ts_diff;
  logic [TS_W:0]      chk_diff;
  logic [TS_W:0]      child_sum;
  logic [TOTAL_W:0]   total_sum;
  logic [TOTAL_W-1:0] total_new;

  assign sp_m1    = sp_q - LEVEL_W'(1);
  assign is_start = (cmd_q == CMD_START);
  assign is_end   = (cmd_q == CMD_END);
  assign id_ok    = (32'(id_q) < NUM_FUNCS);
  assign end_ok   = is_end && (status_q == ST_OK);

  // eval: inclusive duration, saturating at the top of the 32-bit range
  assign ts_diff = {1'b0, ts_q} - {1'b0, start_rd};
  always_comb begin
    if (ts_diff[TS_W-1:0] == {TS_W{1'b1}}) incl_d = {TS_W{1'b1}};
    else                                   incl_d = ts_diff[TS_W-1:0] + TS_W'(1);
  end

  always_comb begin
    status_d = ST_OK;
    if (is_start) begin
      if (32'(sp_q) >= STACK_DEPTH) status_d = ST_FULL;
    end else if (is_end) begin
      if (sp_q == '0)       status_d = ST_EMPTY;
      else if (ts_diff[TS_W]) status_d = ST_ORDER;
    end
  end

  // check: exclusive = inclusive - child time, borrow means child overran
  assign chk_diff = {1'b0, incl_q} - {1'b0, child_q};

  // commit: saturating adds for the total and the parent's child time
  assign total_sum = {1'b0, total_old_q} + (TOTAL_W + 1)'(inv_q);
  assign total_new = total_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : total_sum[TOTAL_W-1:0];
  assign child_sum = {1'b0, child_rd} + {1'b0, incl_q};

  always_comb begin
    sp_d = sp_q;
    if (cmd_i.eval) begin
      if (is_start && status_d == ST_OK) sp_d = sp_q + LEVEL_W'(1);
      else if (is_end && sp_q != '0)     sp_d = sp_m1;
    end
  end

  // memory ports
  assign start_we    = cmd_i.eval && is_start && (status_d == ST_OK);
  assign child_we    = start_we || (cmd_i.commit && end_ok && (sp_q != '0));
  assign child_waddr = cmd_i.commit ? sp_m1[STACK_AW-1:0] : sp_q[STACK_AW-1:0];
  assign child_wdata = cmd_i.commit ?
                       (child_sum[TS_W] ? {TS_W{1'b1}} : child_sum[TS_W-1:0]) : '0;
  assign total_we    = cmd_i.commit && end_ok && id_ok;
  assign total_wdata = total_new;
  assign total_raddr = cmd_i.load ? item_i.func_id : id_q;

  csxt_ram #(.WIDTH(TS_W), .DEPTH(STACK_DEPTH)) u_start_ram (
    .clk_i   (clk_i),
    .we_i    (start_we),
    .waddr_i (sp_q[STACK_AW-1:0]),
    .wdata_i (ts_q),
    .raddr_i (sp_m1[STACK_AW-1:0]),
    .rdata_o (start_rd)
  );

  // read at top-1: top on load, parent during check (pointer already popped)
  csxt_ram #(.WIDTH(TS_W), .DEPTH(STACK_DEPTH)) u_child_ram (
    .clk_i   (clk_i),
    .we_i    (child_we),
    .waddr_i (child_waddr),
    .wdata_i (child_wdata),
    .raddr_i (sp_m1[STACK_AW-1:0]),
    .rdata_o (child_rd)
  );

  csxt_ram #(.WIDTH(TOTAL_W), .DEPTH(TOTAL_DEPTH)) u_total_ram (
    .clk_i   (clk_i),
    .we_i    (total_we),
    .waddr_i (id_q),
    .wdata_i (total_wdata),
    .raddr_i (total_raddr),
    .rdata_o (total_rd)
  );

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= item_i.cmd;
      id_q  <= item_i.func_id;
      ts_q  <= item_i.timestamp;
    end
    if (cmd_i.eval) begin
      incl_q      <= incl_d;
      child_q     <= child_rd;
      total_old_q <= (id_ok && valid_q[id_q]) ? total_rd : '0;
    end
    if (cmd_i.check) begin
      inv_q <= chk_diff[TS_W-1:0];
    end
    if (cmd_i.commit) begin
      result_q.out_id          <= id_q;
      result_q.invocation_time <= end_ok ? inv_q : '0;
      result_q.total_time      <= (end_ok && id_ok) ? total_new : total_old_q;
      result_q.stack_level     <= sp_q;
      result_q.status          <= status_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q     <= '0;
      valid_q  <= '0;
      status_q <= ST_OK;
      done_q   <= 1'b0;
    end else begin
      sp_q   <= sp_d;
      done_q <= cmd_i.commit;
      if (cmd_i.eval) begin
        status_q <= status_d;
      end else if (cmd_i.check && is_end && status_q == ST_OK && chk_diff[TS_W]) begin
        status_q <= ST_ORDER;
      end
      if (total_we) valid_q[id_q] <= 1'b1;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(sp_q) <= STACK_DEPTH)
    else $error("stack pointer beyond depth");

  a_done_after_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(cmd_i.commit))
    else $error("result strobe without commit");

  a_order_no_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && (result_q.status == ST_ORDER || result_q.status == ST_EMPTY)
      |-> result_q.invocation_time == '0)
    else $error("failed end reports exclusive time");

  a_full_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && result_q.status == ST_FULL |-> 32'(result_q.stack_level) == STACK_DEPTH)
    else $error("full status with stack not full");

  a_empty_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && result_q.status == ST_EMPTY |-> result_q.stack_level == '0)
    else $error("empty status with open invocations");

endmodule

FILE: test/call_stack_exclusive_time_core_tb.sv
// Self-checking testbench for the call stack exclusive time tracker core.
`timescale 1ns / 1ps
module call_stack_exclusive_time_core_tb;
  import csxt_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam logic [TS_W-1:0]    TS_MAX    = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef struct {
    item_t   ev;
    bit      pinned;
    result_t res;
  } trace_row_t;

  logic    clk_i = 1'b0;
  logic    rst_ni;
  logic    start;
  item_t   item_i;
  logic    busy;
  logic    done_o;
  result_t result_o;

  // typed-in expectation travels with the transaction it belongs to
  logic    pin_valid;
  result_t pin_res;

  // tracker state as the testbench sees it
  logic [TS_W-1:0]    open_start_ts   [STACK_DEPTH];
  logic [TS_W-1:0]    open_child_time [STACK_DEPTH];
  int                 open_depth;
  logic [TOTAL_W-1:0] func_total      [NUM_FUNCS];

  result_t    pending_results [$];
  int         mismatch_count = 0;
  trace_row_t trace_rows [$];

  // stimulus-side view of the open calls
  logic [TS_W-1:0] gen_now;
  logic [ID_W-1:0] gen_ids [$];

  call_stack_exclusive_time_core i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .item_i   (item_i),
    .busy     (busy),
    .done_o   (done_o),
    .result_o (result_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic item_t mk_event(cmd_e c, logic [ID_W-1:0] id, logic [TS_W-1:0] ts);
    item_t ev;
    ev.cmd       = c;
    ev.func_id   = id;
    ev.timestamp = ts;
    return ev;
  endfunction

  function automatic result_t mk_result(logic [ID_W-1:0] id, logic [TS_W-1:0] inv,
                                        logic [TOTAL_W-1:0] total, int level, status_e st);
    result_t r;
    r.out_id          = id;
    r.invocation_time = inv;
    r.total_time      = total;
    r.stack_level     = LEVEL_W'(level);
    r.status          = st;
    return r;
  endfunction

  // Applies one event to the tracker state and returns the result it produces.
  function automatic result_t exclusive_time_result(item_t ev);
    result_t          r;
    logic [TS_W:0]    incl;
    logic [TS_W:0]    child_sum;
    logic [TOTAL_W:0] total_sum;
    int               top;
    r = '0;
    r.out_id = ev.func_id;
    r.status = ST_OK;
    case (ev.cmd)
      CMD_START: begin
        if (open_depth >= STACK_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          open_start_ts[open_depth]   = ev.timestamp;
          open_child_time[open_depth] = '0;
          open_depth++;
        end
      end
      CMD_END: begin
        if (open_depth == 0) begin
          r.status = ST_EMPTY;
        end else begin
          open_depth--;
          top = open_depth;
          if (ev.timestamp < open_start_ts[top]) begin
            r.status = ST_ORDER;
          end else begin
            incl = {1'b0, ev.timestamp} - {1'b0, open_start_ts[top]} + 1;
            if (incl[TS_W]) incl = {1'b0, TS_MAX};
            if ({1'b0, open_child_time[top]} > incl) begin
              r.status = ST_ORDER;
            end else begin
              r.invocation_time = incl[TS_W-1:0] - open_child_time[top];
              total_sum = {1'b0, func_total[ev.func_id]} +
                          (TOTAL_W + 1)'(r.invocation_time);
              func_total[ev.func_id] = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
              if (open_depth > 0) begin
                child_sum = {1'b0, open_child_time[open_depth-1]} + incl;
                open_child_time[open_depth-1] = child_sum[TS_W] ? TS_MAX : child_sum[TS_W-1:0];
              end
            end
          end
        end
      end
      default: ;  // both read codes leave the state alone
    endcase
    r.total_time  = func_total[ev.func_id];
    r.stack_level = LEVEL_W'(open_depth);
    return r;
  endfunction

  function automatic void check_field(string name, logic [TOTAL_W-1:0] want,
                                      logic [TOTAL_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  // Result first, then the event taken at the same edge.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (done_o !== 1'b0) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with no transaction outstanding, expected none actual %h",
                   $time, result_o);
        end else begin
          want = pending_results.pop_front();
          check_field("out_id", TOTAL_W'(want.out_id), TOTAL_W'(result_o.out_id));
          check_field("invocation_time", TOTAL_W'(want.invocation_time),
                      TOTAL_W'(result_o.invocation_time));
          check_field("total_time", want.total_time, result_o.total_time);
          check_field("stack_level", TOTAL_W'(want.stack_level),
                      TOTAL_W'(result_o.stack_level));
          check_field("status", TOTAL_W'(want.status), TOTAL_W'(result_o.status));
        end
      end
      if (start && !busy) begin
        want = exclusive_time_result(item_i);
        if (pin_valid) want = pin_res;
        pending_results.push_back(want);
      end
    end
  end

  // Called at a rising edge; returns at the edge that takes the transaction.
  task automatic send_event(item_t ev, bit pinned, result_t res, int idle_pct);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start     <= 1'b1;
    item_i    <= ev;
    pin_valid <= pinned;
    pin_res   <= res;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Mostly well-nested start/end pairs with rising timestamps; some noise and reads.
  task automatic random_traffic(int count, int idle_pct);
    item_t ev;
    int    pick;
    int    push_bias;
    int    step;
    push_bias = 50;
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) push_bias = $urandom_range(20, 85);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        ev = mk_event(cmd_e'($urandom_range(0, 3)), ID_W'($urandom_range(0, 63)), $urandom);
        if (ev.cmd == CMD_START && gen_ids.size() < STACK_DEPTH) gen_ids.push_back(ev.func_id);
        if (ev.cmd == CMD_END && gen_ids.size() > 0) void'(gen_ids.pop_back());
      end else if (pick < 14) begin
        ev = mk_event(($urandom_range(0, 1) != 0) ? CMD_READ : CMD_READ_ALT,
                      ID_W'($urandom_range(0, 63)), gen_now);
      end else begin
        step = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1 << 24) : $urandom_range(0, 16);
        gen_now = gen_now + TS_W'(step);
        if (gen_ids.size() == 0 ||
            (gen_ids.size() < STACK_DEPTH && $urandom_range(0, 99) < push_bias) ||
            (gen_ids.size() == STACK_DEPTH && $urandom_range(0, 9) == 0)) begin
          ev = mk_event(CMD_START, ID_W'($urandom_range(0, 63)), gen_now);
          if (gen_ids.size() < STACK_DEPTH) gen_ids.push_back(ev.func_id);
        end else begin
          ev = mk_event(CMD_END, gen_ids.pop_back(), gen_now);
        end
      end
      send_event(ev, 1'b0, '0, idle_pct);
    end
  endtask

  initial begin
    rst_ni    <= 1'b0;
    start     <= 1'b0;
    item_i    <= '0;
    pin_valid <= 1'b0;
    pin_res   <= '0;
    open_depth = 0;
    gen_now    = '0;
    for (int f = 0; f < NUM_FUNCS; f++) func_total[f] = '0;

    // read after reset, both read codes, end on empty stack
    trace_rows.push_back('{mk_event(CMD_READ, 0, 0), 1'b1, mk_result(0, 0, 0, 0, ST_OK)});
    trace_rows.push_back('{mk_event(CMD_READ_ALT, 63, TS_MAX), 1'b1,
                           mk_result(63, 0, 0, 0, ST_OK)});
    trace_rows.push_back('{mk_event(CMD_END, 5, 7), 1'b1, mk_result(5, 0, 0, 0, ST_EMPTY)});
    // simple nesting
    trace_rows.push_back('{mk_event(CMD_START, 1, 100), 1'b1, mk_result(1, 0, 0, 1, ST_OK)});
    trace_rows.push_back('{mk_event(CMD_START, 2, 105), 1'b1, mk_result(2, 0, 0, 2, ST_OK)});
    trace_rows.push_back('{mk_event(CMD_END, 2, 109), 1'b0, '0});
    trace_rows.push_back('{mk_event(CMD_END, 1, 120), 1'b0, '0});
    trace_rows.push_back('{mk_event(CMD_READ, 2, 120), 1'b0, '0});
    // end earlier than its start
    trace_rows.push_back('{mk_event(CMD_START, 3, 200), 1'b1, mk_result(3, 0, 0, 1, ST_OK)});
    trace_rows.push_back('{mk_event(CMD_END, 3, 199), 1'b1, mk_result(3, 0, 0, 0, ST_ORDER)});
    // child time longer than the parent's duration
    trace_rows.push_back('{mk_event(CMD_START, 4, 300), 1'b1, mk_result(4, 0, 0, 1, ST_OK)});
    trace_rows.push_back('{mk_event(CMD_START, 5, 300), 1'b1, mk_result(5, 0, 0, 2, ST_OK)});
    trace_rows.push_back('{mk_event(CMD_END, 5, 310), 1'b0, '0});
    trace_rows.push_back('{mk_event(CMD_END, 4, 305), 1'b1, mk_result(4, 0, 0, 0, ST_ORDER)});
    // full-range duration saturates to all ones
    trace_rows.push_back('{mk_event(CMD_START, 6, 0), 1'b1, mk_result(6, 0, 0, 1, ST_OK)});
    trace_rows.push_back('{mk_event(CMD_END, 6, TS_MAX), 1'b1,
                           mk_result(6, TS_MAX, TOTAL_W'(TS_MAX), 0, ST_OK)});
    // parent child time saturates
    trace_rows.push_back('{mk_event(CMD_START, 7, 0), 1'b1, mk_result(7, 0, 0, 1, ST_OK)});
    trace_rows.push_back('{mk_event(CMD_START, 8, 0), 1'b1, mk_result(8, 0, 0, 2, ST_OK)});
    trace_rows.push_back('{mk_event(CMD_END, 8, TS_MAX), 1'b1,
                           mk_result(8, TS_MAX, TOTAL_W'(TS_MAX), 1, ST_OK)});
    trace_rows.push_back('{mk_event(CMD_START, 9, 0), 1'b1, mk_result(9, 0, 0, 2, ST_OK)});
    trace_rows.push_back('{mk_event(CMD_END, 9, 0), 1'b0, '0});
    trace_rows.push_back('{mk_event(CMD_END, 7, TS_MAX), 1'b1, mk_result(7, 0, 0, 0, ST_OK)});
    trace_rows.push_back('{mk_event(CMD_READ, 7, TS_MAX), 1'b0, '0});

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (trace_rows[i]) send_event(trace_rows[i].ev, trace_rows[i].pinned,
                                       trace_rows[i].res, 19);

    // fill past the top, then unwind past the bottom
    for (int i = 0; i <= STACK_DEPTH; i++)
      send_event(mk_event(CMD_START, ID_W'(i), TS_W'(1000 + i)), 1'b0, '0, 19);
    for (int i = STACK_DEPTH; i >= 0; i--)
      send_event(mk_event(CMD_END, ID_W'(i), TS_W'(2000 + i)), 1'b0, '0, 19);
    drain_results();

    random_traffic(315, 19);
    drain_results();
    random_traffic(315, 55);
    drain_results();
    random_traffic(315, 0);

    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
